[sv/lmdm_pkg.sv]
package lmdm_pkg;

    // Matrix geometry defaults and fixed field widths.
    localparam int STROBE_LINES_DEF = 16;
    localparam int DATA_LINES_DEF   = 16;
    localparam int LAMP_SLOTS       = 256;
    localparam int LINE_SLOTS       = 16;
    localparam int ADDR_W           = 8;
    localparam int LINE_W           = 4;
    localparam int COL_W            = 4;
    localparam int PAT_W            = 16;
    localparam int CNT_W            = 32;
    localparam int TICK_W           = 16;

    // Action codes carried in a command transaction.
    localparam logic [1:0] ACT_STROBE = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // One lamp's entry in the lamp memory.
    typedef struct packed {
        logic [CNT_W-1:0] on_count;
        logic [CNT_W-1:0] off_count;
        logic [CNT_W-1:0] captured_period;
        logic [CNT_W-1:0] captured_duty;
        logic             powered;
    } lamp_entry_t;

    // Saturating 32-bit addition.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
        end
    endfunction

endpackage

[sv/lmdm_if.sv]
// Command channel: one transaction carries one action.
interface lmdm_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [lmdm_pkg::LINE_W-1:0] strobe_line;
    logic [lmdm_pkg::PAT_W-1:0] column_bits;
    logic [lmdm_pkg::TICK_W-1:0] tick_cycles;
    logic [lmdm_pkg::ADDR_W-1:0] lamp_index;

    modport source (output valid, action, strobe_line, column_bits, tick_cycles, lamp_index,
                    input ready);
    modport sink (input valid, action, strobe_line, column_bits, tick_cycles, lamp_index,
                  output ready);
endinterface

// Result channel: one transaction per lamp read.
interface lmdm_res_if;
    logic                        valid;
    logic                        ready;
    logic [lmdm_pkg::CNT_W-1:0] period_cycles;
    logic [lmdm_pkg::CNT_W-1:0] duty_cycles;
    logic                        lamp_powered;

    modport source (output valid, period_cycles, duty_cycles, lamp_powered, input ready);
    modport sink (input valid, period_cycles, duty_cycles, lamp_powered, output ready);
endinterface

[sv/lamp_matrix_duty_meter.sv]
// Data write: accepted while idle; the block stays ready for the next command.
// Lamp read: memory read register, then output register once it is free; one item at a time.
// Strobe change: busy sweeping the DATA_LINES lamps of the new line; tick: busy sweeping all
// STROBE_LINES * DATA_LINES lamps; the lamp memory's one read and one write port handle one lamp per cycle.
// Reset (rst_n, asynchronous) clears the control state, the line patterns, the active strobe
// and one valid bit per lamp entry, so every lamp reads as zero with no clearing pass.
module lamp_matrix_duty_meter #(
    parameter int STROBE_LINES = lmdm_pkg::STROBE_LINES_DEF,
    parameter int DATA_LINES   = lmdm_pkg::DATA_LINES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lmdm_cmd_if.sink   cmd,
    lmdm_res_if.source res
);

    localparam int LAMP_COUNT = STROBE_LINES * DATA_LINES;
    localparam logic [lmdm_pkg::PAT_W-1:0] COL_MASK =
        lmdm_pkg::PAT_W'((32'd1 << DATA_LINES) - 32'd1);
    localparam logic [lmdm_pkg::COL_W-1:0] LAST_COL = lmdm_pkg::COL_W'(DATA_LINES - 1);
    localparam logic [lmdm_pkg::LINE_W-1:0] LAST_STROBE = lmdm_pkg::LINE_W'(STROBE_LINES - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    typedef enum logic {
        MODE_CAPTURE = 1'b0,
        MODE_TICK    = 1'b1
    } sweep_mode_t;

    state_t state_reg, state_next;
    sweep_mode_t mode_reg;

    logic [lmdm_pkg::LINE_W-1:0] active_reg;
    logic [lmdm_pkg::PAT_W-1:0]  line_pattern_reg [lmdm_pkg::LINE_SLOTS];
    logic [lmdm_pkg::TICK_W-1:0] cycles_reg;
    logic                        oob_reg;

    // Issue stage of the sweep.
    logic                         iss_live_reg;
    logic [lmdm_pkg::ADDR_W-1:0]  iss_addr_reg;
    logic [lmdm_pkg::COL_W-1:0]   iss_col_reg;
    logic [lmdm_pkg::LINE_W-1:0]  iss_strobe_reg;
    logic                         iss_last;

    // Write-back stage of the sweep.
    logic                         wb_live_reg;
    logic [lmdm_pkg::ADDR_W-1:0]  wb_addr_reg;
    logic [lmdm_pkg::COL_W-1:0]   wb_col_reg;
    logic [lmdm_pkg::LINE_W-1:0]  wb_strobe_reg;

    // Lamp memory and its valid bits.
    lmdm_pkg::lamp_entry_t       lamp_mem [lmdm_pkg::LAMP_SLOTS];
    lmdm_pkg::lamp_entry_t       mem_q_reg;
    logic                        mem_q_vld_reg;
    logic [lmdm_pkg::LAMP_SLOTS-1:0] entry_valid_reg;
    logic                        mem_rd_en;
    logic [lmdm_pkg::ADDR_W-1:0] mem_rd_addr;
    logic                        mem_we;
    lmdm_pkg::lamp_entry_t       mem_rd_data;
    lmdm_pkg::lamp_entry_t       mem_wdata;

    // Output register.
    logic                        res_valid_reg;
    logic [lmdm_pkg::CNT_W-1:0]  res_period_reg;
    logic [lmdm_pkg::CNT_W-1:0]  res_duty_reg;
    logic                        res_powered_reg;

    logic cmd_fire;
    logic strobe_go;
    logic lamp_bit;
    logic res_load;
    logic [lmdm_pkg::PAT_W-1:0] wb_pattern;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign strobe_go = (int'(cmd.strobe_line) < STROBE_LINES) && (cmd.strobe_line != active_reg);

    assign res.valid         = res_valid_reg;
    assign res.period_cycles = res_period_reg;
    assign res.duty_cycles   = res_duty_reg;
    assign res.lamp_powered  = res_powered_reg;

    // The sweep stops after the last column of the line, or of the whole matrix for a tick.
    assign iss_last = (iss_col_reg == LAST_COL)
                   && (mode_reg == MODE_CAPTURE || iss_strobe_reg == LAST_STROBE);

    // Memory read port: a lamp read from the command, otherwise the sweep's issue stage.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = iss_addr_reg;
        if (state_reg == ST_IDLE)
        begin
            mem_rd_en   = cmd_fire && (cmd.action == lmdm_pkg::ACT_READ);
            mem_rd_addr = cmd.lamp_index;
        end
        else if (state_reg == ST_SWEEP)
        begin
            mem_rd_en = iss_live_reg;
        end
    end

    // Entries never written read as zero.
    assign mem_rd_data = mem_q_vld_reg ? mem_q_reg : '0;

    // Pattern seen by the lamp in the write-back stage.
    assign wb_pattern = (wb_strobe_reg == active_reg) ? line_pattern_reg[active_reg] : '0;
    assign lamp_bit   = wb_pattern[wb_col_reg];

    // Modify step of the read-modify-write.
    always_comb
    begin
        mem_we    = (state_reg == ST_SWEEP) && wb_live_reg;
        mem_wdata = mem_rd_data;
        if (mode_reg == MODE_CAPTURE)
        begin
            mem_wdata.captured_period = lmdm_pkg::sat_add(mem_rd_data.on_count,
                                                          mem_rd_data.off_count);
            mem_wdata.captured_duty   = mem_rd_data.on_count;
            mem_wdata.on_count        = '0;
            mem_wdata.off_count       = '0;
        end
        else if (lamp_bit)
        begin
            mem_wdata.powered  = 1'b1;
            mem_wdata.on_count = lmdm_pkg::sat_add(mem_rd_data.on_count,
                                                   lmdm_pkg::CNT_W'(cycles_reg));
        end
        else
        begin
            mem_wdata.powered   = 1'b0;
            mem_wdata.off_count = lmdm_pkg::sat_add(mem_rd_data.off_count,
                                                    lmdm_pkg::CNT_W'(cycles_reg));
        end
    end

    // Lamp memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lamp_mem[wb_addr_reg] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            mem_q_reg     <= lamp_mem[mem_rd_addr];
            mem_q_vld_reg <= entry_valid_reg[mem_rd_addr];
        end
    end

    // Valid bits: set on the first write of each entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            entry_valid_reg[wb_addr_reg] <= 1'b1;
        end
    end

    assign res_load = (state_reg == ST_READ) && (!res_valid_reg || res.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.action == lmdm_pkg::ACT_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd.action == lmdm_pkg::ACT_TICK
                             || (cmd.action == lmdm_pkg::ACT_STROBE && strobe_go))
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!iss_live_reg && wb_live_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, line patterns and the sweep pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_CAPTURE;
            active_reg    <= '0;
            iss_live_reg  <= 1'b0;
            wb_live_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < lmdm_pkg::LINE_SLOTS; i++)
            begin
                line_pattern_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Command decode while idle.
            if (cmd_fire)
            begin
                unique case (cmd.action)
                    lmdm_pkg::ACT_STROBE:
                    begin
                        if (strobe_go)
                        begin
                            mode_reg     <= MODE_CAPTURE;
                            active_reg   <= cmd.strobe_line;
                            iss_live_reg <= 1'b1;
                        end
                    end
                    lmdm_pkg::ACT_DATA:
                    begin
                        line_pattern_reg[active_reg] <= cmd.column_bits & COL_MASK;
                    end
                    lmdm_pkg::ACT_TICK:
                    begin
                        mode_reg     <= MODE_TICK;
                        iss_live_reg <= 1'b1;
                    end
                    lmdm_pkg::ACT_READ:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (state_reg == ST_SWEEP)
            begin
                if (iss_live_reg && iss_last)
                begin
                    iss_live_reg <= 1'b0;
                end
            end

            // Write-back stage follows the issue stage in the next cycle.
            wb_live_reg <= (state_reg == ST_SWEEP) && iss_live_reg;

            // Output register: loaded from a finished read, emptied by the sink.
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Sweep addressing and the payload of a transaction.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cycles_reg <= cmd.tick_cycles;
            oob_reg    <= !(int'(cmd.lamp_index) < LAMP_COUNT);
            iss_col_reg <= '0;
            if (cmd.action == lmdm_pkg::ACT_TICK)
            begin
                iss_addr_reg   <= '0;
                iss_strobe_reg <= '0;
            end
            else
            begin
                iss_addr_reg   <= lmdm_pkg::ADDR_W'(int'(cmd.strobe_line) * DATA_LINES);
                iss_strobe_reg <= cmd.strobe_line;
            end
        end
        else if (state_reg == ST_SWEEP && iss_live_reg)
        begin
            iss_addr_reg <= iss_addr_reg + 1'b1;
            if (iss_col_reg == LAST_COL)
            begin
                iss_col_reg    <= '0;
                iss_strobe_reg <= iss_strobe_reg + 1'b1;
            end
            else
            begin
                iss_col_reg <= iss_col_reg + 1'b1;
            end
        end

        wb_addr_reg   <= iss_addr_reg;
        wb_col_reg    <= iss_col_reg;
        wb_strobe_reg <= iss_strobe_reg;

        if (res_load)
        begin
            res_period_reg  <= oob_reg ? '0 : mem_rd_data.captured_period;
            res_duty_reg    <= oob_reg ? '0 : mem_rd_data.captured_duty;
            res_powered_reg <= oob_reg ? 1'b0 : mem_rd_data.powered;
        end
    end

    // A write-back never targets the entry being read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_rd_en) |-> (wb_addr_reg != mem_rd_addr))
        else $error("lamp memory read and write collide on one entry");

    // Every sweep cycle has an entry in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (iss_live_reg || wb_live_reg))
        else $error("sweep state with no entry in flight");

    // Write-backs stay inside the lamp matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (int'(wb_addr_reg) < LAMP_COUNT))
        else $error("write-back outside the lamp matrix");

    // A capture touches only lamps of the newly selected line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mode_reg == MODE_CAPTURE) |-> (wb_strobe_reg == active_reg))
        else $error("capture written to a lamp off the active line");

    // A finished read waits in its state until the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && res_valid_reg && !res.ready) |=> (state_reg == ST_READ))
        else $error("read result left before the output register was free");

endmodule

[test/lamp_matrix_duty_meter_tb.sv]
module lamp_matrix_duty_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int COMMAND_TARGET  = 1500;
    localparam int CALM_FROM       = 1300;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 300;
    localparam int STALL_LIMIT     = 4000;

    typedef struct packed {
        logic [1:0]                  action;
        logic [lmdm_pkg::LINE_W-1:0] strobe_line;
        logic [lmdm_pkg::PAT_W-1:0]  column_bits;
        logic [lmdm_pkg::TICK_W-1:0] tick_cycles;
        logic [lmdm_pkg::ADDR_W-1:0] lamp_index;
    } lamp_cmd_t;

    typedef struct packed {
        logic [lmdm_pkg::CNT_W-1:0] period_cycles;
        logic [lmdm_pkg::CNT_W-1:0] duty_cycles;
        logic                       lamp_powered;
    } lamp_readout_t;

    // Tracks every lamp's counters and holds the readouts still owed by the block.
    class lamp_duty_tracker;
        logic [lmdm_pkg::CNT_W-1:0]  on_cnt [lmdm_pkg::LAMP_SLOTS];
        logic [lmdm_pkg::CNT_W-1:0]  off_cnt [lmdm_pkg::LAMP_SLOTS];
        logic [lmdm_pkg::CNT_W-1:0]  period_cap [lmdm_pkg::LAMP_SLOTS];
        logic [lmdm_pkg::CNT_W-1:0]  duty_cap [lmdm_pkg::LAMP_SLOTS];
        logic                        powered [lmdm_pkg::LAMP_SLOTS];
        logic [lmdm_pkg::PAT_W-1:0]  pattern [lmdm_pkg::LINE_SLOTS];
        logic [lmdm_pkg::LINE_W-1:0] active_line;
        lamp_readout_t               readout_q [$];
        int errors;
        int reads;
        int ticks;
        int captures;
        int repeats;
        int data_writes;

        function new();
            for (int i = 0; i < lmdm_pkg::LAMP_SLOTS; i++)
            begin
                on_cnt[i]     = '0;
                off_cnt[i]    = '0;
                period_cap[i] = '0;
                duty_cap[i]   = '0;
                powered[i]    = 1'b0;
            end
            for (int i = 0; i < lmdm_pkg::LINE_SLOTS; i++)
            begin
                pattern[i] = '0;
            end
            active_line = '0;
            errors      = 0;
            reads       = 0;
            ticks       = 0;
            captures    = 0;
            repeats     = 0;
            data_writes = 0;
        endfunction

        // Counters stick at the top value rather than wrapping.
        function logic [lmdm_pkg::CNT_W-1:0] add_clamped(logic [lmdm_pkg::CNT_W-1:0] a,
                                                         logic [lmdm_pkg::CNT_W-1:0] b);
            if (a > ~b)
                return '1;
            return a + b;
        endfunction

        // Applies one accepted command transaction to the lamp state.
        function void note_command(lamp_cmd_t c);
            int lamp;
            lamp_readout_t want;
            case (c.action)
                lmdm_pkg::ACT_STROBE:
                begin
                    if (c.strobe_line == active_line)
                    begin
                        repeats++;
                    end
                    else
                    begin
                        // Capture and restart every lamp on the newly selected line.
                        for (int col = 0; col < lmdm_pkg::DATA_LINES_DEF; col++)
                        begin
                            lamp = c.strobe_line * lmdm_pkg::DATA_LINES_DEF + col;
                            period_cap[lamp] = add_clamped(on_cnt[lamp], off_cnt[lamp]);
                            duty_cap[lamp]   = on_cnt[lamp];
                            on_cnt[lamp]     = '0;
                            off_cnt[lamp]    = '0;
                        end
                        active_line = c.strobe_line;
                        captures++;
                    end
                end
                lmdm_pkg::ACT_DATA:
                begin
                    pattern[active_line] = c.column_bits;
                    data_writes++;
                end
                lmdm_pkg::ACT_TICK:
                begin
                    // Only driven lamps on the active line count as on.
                    for (lamp = 0; lamp < lmdm_pkg::LAMP_SLOTS; lamp++)
                    begin
                        if (lamp / lmdm_pkg::DATA_LINES_DEF == active_line &&
                            pattern[active_line][lamp % lmdm_pkg::DATA_LINES_DEF])
                        begin
                            powered[lamp] = 1'b1;
                            on_cnt[lamp]  = add_clamped(on_cnt[lamp],
                                                        lmdm_pkg::CNT_W'(c.tick_cycles));
                        end
                        else
                        begin
                            powered[lamp] = 1'b0;
                            off_cnt[lamp] = add_clamped(off_cnt[lamp],
                                                        lmdm_pkg::CNT_W'(c.tick_cycles));
                        end
                    end
                    ticks++;
                end
                default:
                begin
                    want.period_cycles = period_cap[c.lamp_index];
                    want.duty_cycles   = duty_cap[c.lamp_index];
                    want.lamp_powered  = powered[c.lamp_index];
                    readout_q.push_back(want);
                    reads++;
                end
            endcase
        endfunction

        // Compares one accepted result transaction with the oldest readout owed.
        function void check_result(lamp_readout_t got);
            lamp_readout_t want;
            if (readout_q.size() == 0)
            begin
                $display("%0t: unexpected readout, period %0d duty %0d powered %0d",
                         $time, got.period_cycles, got.duty_cycles, got.lamp_powered);
                errors++;
                return;
            end
            want = readout_q.pop_front();
            if (got.period_cycles !== want.period_cycles)
            begin
                $display("%0t: period_cycles expected %0d, actual %0d",
                         $time, want.period_cycles, got.period_cycles);
                errors++;
            end
            if (got.duty_cycles !== want.duty_cycles)
            begin
                $display("%0t: duty_cycles expected %0d, actual %0d",
                         $time, want.duty_cycles, got.duty_cycles);
                errors++;
            end
            if (got.lamp_powered !== want.lamp_powered)
            begin
                $display("%0t: lamp_powered expected %0b, actual %0b",
                         $time, want.lamp_powered, got.lamp_powered);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lmdm_cmd_if cmd_ch ();
    lmdm_res_if res_ch ();

    lamp_duty_tracker tracker = new();

    int                          items_sent = 0;
    int                          idle_cycles = 0;
    logic [lmdm_pkg::LINE_W-1:0] drv_line = '0;
    logic                        pressure_done = 1'b0;
    logic                        calm;

    assign calm = (items_sent >= CALM_FROM);

    lamp_matrix_duty_meter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Builds a command with every field random, then sets the field the action uses.
    function automatic lamp_cmd_t cmd_of(logic [1:0] act, int unsigned arg);
        lamp_cmd_t c;
        c.action      = act;
        c.strobe_line = lmdm_pkg::LINE_W'($urandom);
        c.column_bits = lmdm_pkg::PAT_W'($urandom);
        c.tick_cycles = lmdm_pkg::TICK_W'($urandom);
        c.lamp_index  = lmdm_pkg::ADDR_W'($urandom);
        case (act)
            lmdm_pkg::ACT_STROBE: c.strobe_line = arg[lmdm_pkg::LINE_W-1:0];
            lmdm_pkg::ACT_DATA:   c.column_bits = arg[lmdm_pkg::PAT_W-1:0];
            lmdm_pkg::ACT_TICK:   c.tick_cycles = arg[lmdm_pkg::TICK_W-1:0];
            default:              c.lamp_index  = arg[lmdm_pkg::ADDR_W-1:0];
        endcase
        return c;
    endfunction

    // Offers one command and holds it until the block takes it.
    task automatic send_cmd(lamp_cmd_t c);
        cmd_ch.action      <= c.action;
        cmd_ch.strobe_line <= c.strobe_line;
        cmd_ch.column_bits <= c.column_bits;
        cmd_ch.tick_cycles <= c.tick_cycles;
        cmd_ch.lamp_index  <= c.lamp_index;
        cmd_ch.valid       <= 1'b1;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        // A strobe write naming the active line changes nothing, so it is not counted.
        if (!(c.action == lmdm_pkg::ACT_STROBE && c.strobe_line == drv_line))
            items_sent++;
        if (c.action == lmdm_pkg::ACT_STROBE)
            drv_line = c.strobe_line;
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Record accepted commands and check accepted results.
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            tracker.note_command({cmd_ch.action, cmd_ch.strobe_line, cmd_ch.column_bits,
                                  cmd_ch.tick_cycles, cmd_ch.lamp_index});
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_result({res_ch.period_cycles, res_ch.duty_cycles,
                                  res_ch.lamp_powered});
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: random stalls, one long hold-off, then steady acceptance.
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!pressure_done && items_sent >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge clk);
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // Reset, command stimulus and end of run.
    initial
    begin
        logic [lmdm_pkg::LINE_W-1:0] next_line;
        int unsigned                 bits;
        int unsigned                 cycles;

        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= lmdm_pkg::ACT_STROBE;
        cmd_ch.strobe_line <= '0;
        cmd_ch.column_bits <= '0;
        cmd_ch.tick_cycles <= '0;
        cmd_ch.lamp_index  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset contents, same-line strobes, full and empty patterns,
        // the largest and smallest ticks and captures on the first and last lines.
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 255));
        send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_DATA, 32'hFFFF));
        send_cmd(cmd_of(lmdm_pkg::ACT_TICK, 32'hFFFF));
        send_cmd(cmd_of(lmdm_pkg::ACT_TICK, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 5));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 16));
        send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, 15));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 255));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 240));
        send_cmd(cmd_of(lmdm_pkg::ACT_DATA, 32'h0000));
        send_cmd(cmd_of(lmdm_pkg::ACT_TICK, 1));
        send_cmd(cmd_of(lmdm_pkg::ACT_DATA, 32'hA5A5));
        send_cmd(cmd_of(lmdm_pkg::ACT_TICK, 12345));
        send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 15));
        send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, 0));
        send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, 15));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 240));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 241));
        send_cmd(cmd_of(lmdm_pkg::ACT_READ, 255));

        // Random part: mostly scan steps as firmware would issue them, some noise.
        while (items_sent < COMMAND_TARGET)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                next_line = drv_line + 1'b1;
                if ($urandom_range(0, 99) < 20)
                    next_line = lmdm_pkg::LINE_W'($urandom);
                send_cmd(cmd_of(lmdm_pkg::ACT_STROBE, next_line));
                repeat ($urandom_range(0, 2))
                    send_cmd(cmd_of(lmdm_pkg::ACT_READ,
                                    next_line * lmdm_pkg::DATA_LINES_DEF +
                                    $urandom_range(0, lmdm_pkg::DATA_LINES_DEF - 1)));
                bits = $urandom_range(0, 65535);
                if ($urandom_range(0, 99) < 15)
                    bits = $urandom_range(0, 1) ? 32'hFFFF : 32'h0000;
                send_cmd(cmd_of(lmdm_pkg::ACT_DATA, bits));
                repeat ($urandom_range(1, 3))
                begin
                    cycles = $urandom_range(0, 65535);
                    if ($urandom_range(0, 9) == 0)
                        cycles = $urandom_range(0, 1) ? 32'hFFFF : 32'h0000;
                    send_cmd(cmd_of(lmdm_pkg::ACT_TICK, cycles));
                    if ($urandom_range(0, 99) < 40)
                        send_cmd(cmd_of(lmdm_pkg::ACT_READ,
                                        $urandom_range(0, lmdm_pkg::LAMP_SLOTS - 1)));
                end
            end
            else
            begin
                send_cmd(cmd_of(2'($urandom_range(0, 3)), $urandom));
            end
        end
        cmd_ch.valid <= 1'b0;

        // Drain the outstanding readouts, then give the block time to show anything extra.
        while (tracker.readout_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d lamp reads, %0d ticks, %0d data writes,", tracker.reads,
                 tracker.ticks, tracker.data_writes);
        $display("%0d line captures and %0d strobe writes to the active line.",
                 tracker.captures, tracker.repeats);
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/lmdm_pkg.sv
sv/lmdm_if.sv
sv/lamp_matrix_duty_meter.sv
test/lamp_matrix_duty_meter_tb.sv
